// ===== src/sms_pkg.sv =====
// shared types and constants for the sms tpdu structure checker
// no dependencies; imported by sms_parser and sms_tpdu_structure_checker
package sms_pkg;

    localparam int DATA_W        = 8;
    localparam int STATUS_W      = 2;
    localparam int MTYPE_W       = 2;
    localparam int TOTAL_LEN_W   = 9;
    localparam int UDL_W         = 8;
    localparam int MAX_LEN_W     = 8;

    localparam logic [MAX_LEN_W-1:0]   MAX_LEN_RESET = 8'd164;
    localparam logic [TOTAL_LEN_W-1:0] TOTAL_LEN_MAX = 9'd511;

    localparam logic [STATUS_W-1:0] ST_VALID     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd2;

    localparam logic [MTYPE_W-1:0] MT_DELIVER = 2'd0;
    localparam logic [MTYPE_W-1:0] MT_SUBMIT  = 2'd1;

    localparam logic [1:0] VPF_NONE     = 2'd0;
    localparam logic [1:0] VPF_RELATIVE = 2'd2;

    localparam logic [DATA_W-1:0] SCTS_OCTETS   = 8'd7;
    localparam logic [DATA_W-1:0] VP_ABS_OCTETS = 8'd7;
    localparam logic [DATA_W-1:0] VP_REL_OCTETS = 8'd1;

    typedef enum logic [3:0] {
        PH_FIRST,
        PH_MR,
        PH_ADDR_LEN,
        PH_ADDR_BODY,
        PH_PID,
        PH_DCS,
        PH_VP,
        PH_SCTS,
        PH_UDL,
        PH_UDATA,
        PH_DONE,
        PH_REPORT
    } t_phase;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [MTYPE_W-1:0]     message_type;
        logic [TOTAL_LEN_W-1:0] total_length;
        logic [UDL_W-1:0]       udl_octet;
    } t_verdict;

endpackage

// ===== src/sms_parser.sv =====
// per-message parse state machine: walks the tpdu layout one octet per step
// and forms the verdict on the last octet; depends on sms_pkg
module sms_parser
    import sms_pkg::*;
#(
    parameter int COUNT_WIDTH = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [DATA_W-1:0]    i_data_byte,
    input  logic                 i_last,
    input  logic [MAX_LEN_W-1:0] i_max_length,
    output t_verdict             o_verdict
);

    localparam int CW_EXT = (COUNT_WIDTH > TOTAL_LEN_W) ? COUNT_WIDTH : TOTAL_LEN_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    t_phase                  r_phase, n_phase, a_phase;
    logic [DATA_W-1:0]       r_first, n_first, a_first;
    logic [DATA_W-1:0]       r_rem, n_rem, a_rem;
    logic [UDL_W-1:0]        r_udl, n_udl, a_udl;
    logic [COUNT_WIDTH-1:0]  r_count, n_count, a_count;
    logic [DATA_W-1:0]       rem_dec;
    logic [DATA_W:0]         addr_octets;
    logic [1:0]              vpf;
    logic [CW_EXT-1:0]       count_ext;

    assign rem_dec     = (r_rem != '0) ? DATA_W'(r_rem - 1'b1) : '0;
    assign addr_octets = (DATA_W+1)'(i_data_byte) + 1'b1;
    assign vpf         = r_first[4:3];

    // advance by one octet
    always_comb begin
        a_phase = r_phase;
        a_first = r_first;
        a_rem   = r_rem;
        a_udl   = r_udl;
        a_count = (r_count != COUNT_MAX) ? COUNT_WIDTH'(r_count + 1'b1) : r_count;
        case (r_phase)
            PH_FIRST: begin
                a_first = i_data_byte;
                if (i_data_byte[1:0] == MT_DELIVER) begin
                    a_phase = PH_ADDR_LEN;
                end else if (i_data_byte[1:0] == MT_SUBMIT) begin
                    a_phase = PH_MR;
                end else begin
                    a_phase = PH_REPORT;
                end
            end
            PH_MR: begin
                a_phase = PH_ADDR_LEN;
            end
            PH_ADDR_LEN: begin
                if (i_data_byte == '0) begin
                    a_phase = PH_PID;
                end else begin
                    a_rem   = DATA_W'((DATA_W+1)'(1) + (addr_octets >> 1));
                    a_phase = PH_ADDR_BODY;
                end
            end
            PH_ADDR_BODY: begin
                a_rem = rem_dec;
                if (rem_dec == '0) begin
                    a_phase = PH_PID;
                end
            end
            PH_PID: begin
                a_phase = PH_DCS;
            end
            PH_DCS: begin
                if (r_first[1:0] == MT_DELIVER) begin
                    a_rem   = SCTS_OCTETS;
                    a_phase = PH_SCTS;
                end else if (vpf == VPF_NONE) begin
                    a_phase = PH_UDL;
                end else begin
                    a_rem   = (vpf == VPF_RELATIVE) ? VP_REL_OCTETS : VP_ABS_OCTETS;
                    a_phase = PH_VP;
                end
            end
            PH_VP, PH_SCTS: begin
                a_rem = rem_dec;
                if (rem_dec == '0) begin
                    a_phase = PH_UDL;
                end
            end
            PH_UDL: begin
                a_udl   = i_data_byte;
                a_rem   = i_data_byte;
                a_phase = (i_data_byte == '0) ? PH_DONE : PH_UDATA;
            end
            PH_UDATA: begin
                a_rem = rem_dec;
                if (rem_dec == '0) begin
                    a_phase = PH_DONE;
                end
            end
            PH_REPORT: begin
                a_phase = PH_DONE;
            end
            default: begin
                a_phase = PH_DONE;
            end
        endcase
    end

    // next state: hold, advance, or clear after the verdict
    always_comb begin
        n_phase = r_phase;
        n_first = r_first;
        n_rem   = r_rem;
        n_udl   = r_udl;
        n_count = r_count;
        if (i_step) begin
            if (i_last) begin
                n_phase = PH_FIRST;
                n_first = '0;
                n_rem   = '0;
                n_udl   = '0;
                n_count = '0;
            end else begin
                n_phase = a_phase;
                n_first = a_first;
                n_rem   = a_rem;
                n_udl   = a_udl;
                n_count = a_count;
            end
        end
    end

    // verdict
    assign count_ext = CW_EXT'(a_count);

    always_comb begin
        if (count_ext > CW_EXT'(i_max_length)) begin
            o_verdict.status = ST_TOO_LONG;
        end else if (a_phase == PH_UDL || a_phase == PH_DONE) begin
            o_verdict.status = ST_VALID;
        end else begin
            o_verdict.status = ST_MALFORMED;
        end
        o_verdict.message_type     = a_first[1:0];
        o_verdict.total_length     = (count_ext > CW_EXT'(TOTAL_LEN_MAX)) ?
                                     TOTAL_LEN_MAX : count_ext[TOTAL_LEN_W-1:0];
        o_verdict.udl_octet        = a_udl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_first <= '0;
            r_rem   <= '0;
            r_udl   <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_first <= n_first;
            r_rem   <= n_rem;
            r_udl   <= n_udl;
            r_count <= n_count;
        end
    end

endmodule

// ===== src/sms_tpdu_structure_checker.sv =====
// sms tpdu structure checker: the verdict for the last octet is registered in the result
// register and raises o_valid; throughput is one octet per cycle except while a last octet
// waits in the input register, only while the result register is full and stalled
// reset (synchronous, active low) clears parse state and both registers' valid flags,
// and sets max_length to 164; depends on sms_pkg and sms_parser
module sms_tpdu_structure_checker
    import sms_pkg::*;
#(
    parameter int COUNT_WIDTH = 9
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [DATA_W-1:0]      i_data_byte,
    input  logic                   i_last,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [STATUS_W-1:0]    o_status,
    output logic [MTYPE_W-1:0]     o_message_type,
    output logic [TOTAL_LEN_W-1:0] o_total_length,
    output logic [UDL_W-1:0]       o_udl_octet,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [MAX_LEN_W-1:0]   i_cfg_max_length
);

    logic                 r_in_valid;
    logic [DATA_W-1:0]    r_in_byte;
    logic                 r_in_last;
    logic                 r_out_valid;
    t_verdict             r_out;
    t_verdict             verdict;
    logic [MAX_LEN_W-1:0] r_max_length;
    logic                 out_open;
    logic                 step;
    logic                 in_take;

    assign out_open = !r_out_valid || !i_stall;
    assign step     = r_in_valid && (!r_in_last || out_open);
    assign o_stall  = r_in_valid && !step;
    assign in_take  = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_length <= i_cfg_max_length;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
    end

    sms_parser #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_data_byte  (r_in_byte),
        .i_last       (r_in_last),
        .i_max_length (r_max_length),
        .o_verdict    (verdict)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_open) begin
            r_out_valid <= step && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= verdict;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out.status;
    assign o_message_type     = r_out.message_type;
    assign o_total_length     = r_out.total_length;
    assign o_udl_octet        = r_out.udl_octet;

`ifndef ASSERT_OFF
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in_last) |=> o_valid)
        else $error("last octet did not produce a result");

    a_stall_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_in_last && r_out_valid && i_stall))
        else $error("input stalled without a blocked last octet");

    a_no_status_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_VALID || o_status == ST_MALFORMED
                     || o_status == ST_TOO_LONG))
        else $error("undefined status code on output");

    a_length_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_total_length != '0))
        else $error("result with zero total length");
`endif

endmodule

// ===== tb/tb_sms_tpdu_structure_checker.sv =====
// self-checking testbench for sms_tpdu_structure_checker: streams tpdu octets, predicts
// each verdict with a behavioral parser and compares it field by field with the block output
// depends on sms_pkg and the sms_tpdu_structure_checker rtl
module tb_sms_tpdu_structure_checker;
    import sms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W       = 9;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              last;
        bit                pause;
    } t_pending_octet;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [DATA_W-1:0]      i_data_byte = '0;
    logic                   i_last = 1'b0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic [MTYPE_W-1:0]     o_message_type;
    logic [TOTAL_LEN_W-1:0] o_total_length;
    logic [UDL_W-1:0]       o_udl_octet;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [MAX_LEN_W-1:0]   i_cfg_max_length = '0;

    t_pending_octet    octets_to_send[$];
    t_pending_octet    head;
    t_verdict          expected_verdicts[$];
    logic [7:0]        tpdu[$];
    int                queued_octets = 0;
    int                errors = 0;
    int                cycle_count = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                long_hold_left = 0;
    logic              in_fire = 1'b0;

    // parser state mirrored from the block
    t_phase            phase = PH_FIRST;
    logic [7:0]        fo_held = '0;
    logic [7:0]        field_left = '0;
    logic [CNT_W-1:0]  octet_count = '0;
    logic [UDL_W-1:0]  udl_seen = '0;
    logic [MAX_LEN_W-1:0] max_len = MAX_LEN_RESET;

    sms_tpdu_structure_checker uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_data_byte        (i_data_byte),
        .i_last             (i_last),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_message_type     (o_message_type),
        .o_total_length     (o_total_length),
        .o_udl_octet        (o_udl_octet),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_max_length   (i_cfg_max_length)
    );

    always #6 i_clk = ~i_clk;

    task automatic parse_octet(input logic [7:0] b, input logic is_last);
        t_verdict v;
        if (octet_count != '1) octet_count++;
        case (phase)
            PH_FIRST: begin
                fo_held = b;
                if (b[1:0] == MT_DELIVER) phase = PH_ADDR_LEN;
                else if (b[1:0] == MT_SUBMIT) phase = PH_MR;
                else phase = PH_REPORT;
            end
            PH_MR: phase = PH_ADDR_LEN;
            PH_ADDR_LEN: begin
                if (b == 8'd0) begin
                    phase = PH_PID;
                end else begin
                    field_left = 8'd1 + 8'((9'(b) + 9'd1) >> 1);
                    phase = PH_ADDR_BODY;
                end
            end
            PH_ADDR_BODY: begin
                if (field_left != 0) field_left--;
                if (field_left == 0) phase = PH_PID;
            end
            PH_PID: phase = PH_DCS;
            PH_DCS: begin
                if (fo_held[1:0] == MT_DELIVER) begin
                    field_left = SCTS_OCTETS;
                    phase = PH_SCTS;
                end else if (fo_held[4:3] == VPF_NONE) begin
                    phase = PH_UDL;
                end else begin
                    field_left = (fo_held[4:3] == VPF_RELATIVE) ?
                                 VP_REL_OCTETS : VP_ABS_OCTETS;
                    phase = PH_VP;
                end
            end
            PH_VP, PH_SCTS: begin
                if (field_left != 0) field_left--;
                if (field_left == 0) phase = PH_UDL;
            end
            PH_UDL: begin
                udl_seen = b;
                field_left = b;
                phase = (b == 8'd0) ? PH_DONE : PH_UDATA;
            end
            PH_UDATA: begin
                if (field_left != 0) field_left--;
                if (field_left == 0) phase = PH_DONE;
            end
            default: phase = PH_DONE;
        endcase
        if (is_last) begin
            if (octet_count > max_len) v.status = ST_TOO_LONG;
            else if (phase == PH_UDL || phase == PH_DONE) v.status = ST_VALID;
            else v.status = ST_MALFORMED;
            v.message_type     = fo_held[1:0];
            v.total_length     = octet_count;
            v.udl_octet        = udl_seen;
            expected_verdicts.insert(expected_verdicts.size(), v);
            phase       = PH_FIRST;
            fo_held     = '0;
            field_left  = '0;
            octet_count = '0;
            udl_seen    = '0;
        end
    endtask

    // udl < 0 ends the message right before the user-data length octet
    task automatic build_tpdu(input logic [7:0] fo, input int digits, input int udl,
                              input int trail);
        int n_vp;
        tpdu.delete();
        tpdu.insert(tpdu.size(), fo);
        if (fo[1:0] == MT_SUBMIT || fo[1:0] == MT_DELIVER) begin
            if (fo[1:0] == MT_SUBMIT) tpdu.insert(tpdu.size(), 8'($urandom));
            tpdu.insert(tpdu.size(), 8'(digits));
            if (digits != 0)
                repeat ((digits + 1) / 2 + 1) tpdu.insert(tpdu.size(), 8'($urandom));
            repeat (2) tpdu.insert(tpdu.size(), 8'($urandom));
            if (fo[1:0] == MT_DELIVER) n_vp = SCTS_OCTETS;
            else if (fo[4:3] == VPF_NONE) n_vp = 0;
            else if (fo[4:3] == VPF_RELATIVE) n_vp = VP_REL_OCTETS;
            else n_vp = VP_ABS_OCTETS;
            repeat (n_vp) tpdu.insert(tpdu.size(), 8'($urandom));
            if (udl >= 0) begin
                tpdu.insert(tpdu.size(), 8'(udl));
                repeat (udl) tpdu.insert(tpdu.size(), 8'($urandom));
                repeat (trail) tpdu.insert(tpdu.size(), 8'($urandom));
            end
        end else begin
            repeat (trail) tpdu.insert(tpdu.size(), 8'($urandom));
        end
    endtask

    task automatic queue_tpdu(input int keep, input bit pause);
        int len;
        t_pending_octet entry;
        len = (keep > 0 && keep < tpdu.size()) ? keep : tpdu.size();
        for (int i = 0; i < len; i++) begin
            entry.data  = tpdu[i];
            entry.last  = (i == len - 1);
            entry.pause = pause && (i == 0);
            octets_to_send.insert(octets_to_send.size(), entry);
        end
        queued_octets += len;
    endtask

    task automatic random_tpdus(input int octet_goal, input int pause_at);
        int start;
        int count;
        int pick;
        int keep;
        int udl;
        int digits;
        logic [7:0] fo;
        start = queued_octets;
        count = 0;
        while (queued_octets - start < octet_goal || count < 2) begin
            pick = $urandom_range(99);
            fo = 8'($urandom);
            if ($urandom_range(3) != 0) fo[1] = 1'b0;
            digits = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(12);
            case ($urandom_range(19))
                0: udl = -1;
                1: udl = $urandom_range(255);
                default: udl = $urandom_range(16);
            endcase
            build_tpdu(fo, digits, udl, ($urandom_range(4) == 0) ? $urandom_range(4, 1) : 0);
            keep = 0;
            if (pick >= 90) begin
                tpdu.delete();
                repeat ($urandom_range(12, 1)) tpdu.insert(tpdu.size(), 8'($urandom));
            end else if (pick >= 75 && tpdu.size() > 1) begin
                keep = $urandom_range(tpdu.size() - 1, 1);
            end
            queue_tpdu(keep, count == pause_at);
            count++;
        end
    endtask

    task automatic wait_drained();
        while (octets_to_send.size() != 0 || i_valid || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_length(input logic [MAX_LEN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_cfg_max_length <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        max_len = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_valid || in_fire) begin
            if (i_rst_n && octets_to_send.size() != 0
                    && !(octets_to_send[0].pause && expected_verdicts.size() != 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                head = octets_to_send.pop_front();
                i_valid     <= 1'b1;
                i_data_byte <= head.data;
                i_last      <= head.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (long_hold_left > 0) begin
            i_stall        <= 1'b1;
            long_hold_left <= long_hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: predict on input transaction, check on output transaction
    always @(posedge i_clk) begin
        t_verdict exp_v;
        in_fire <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) parse_octet(i_data_byte, i_last);
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_verdicts.size() == 0) begin
                $error("unexpected verdict: status %0d type %0d length %0d udl %0d",
                       o_status, o_message_type, o_total_length, o_udl_octet);
                errors++;
            end else begin
                exp_v = expected_verdicts.pop_front();
                if (o_status !== exp_v.status) begin
                    $error("status: expected %0d, got %0d", exp_v.status, o_status);
                    errors++;
                end
                if (o_message_type !== exp_v.message_type) begin
                    $error("message_type: expected %0d, got %0d",
                           exp_v.message_type, o_message_type);
                    errors++;
                end
                if (o_total_length !== exp_v.total_length) begin
                    $error("total_length: expected %0d, got %0d",
                           exp_v.total_length, o_total_length);
                    errors++;
                end
                if (o_udl_octet !== exp_v.udl_octet) begin
                    $error("udl_octet: expected %0d, got %0d",
                           exp_v.udl_octet, o_udl_octet);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        send_idle_pct = 15;
        recv_idle_pct = 88;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed messages at the reset maximum length
        build_tpdu(8'h01, 0, 0, 0);     queue_tpdu(0, 0);
        build_tpdu(8'h11, 11, 3, 0);    queue_tpdu(0, 0);
        build_tpdu(8'h09, 4, 2, 2);     queue_tpdu(0, 0);
        build_tpdu(8'h19, 1, -1, 0);    queue_tpdu(0, 0);
        build_tpdu(8'h01, 0, -1, 0);    queue_tpdu(0, 0);
        build_tpdu(8'h04, 7, 5, 0);     queue_tpdu(0, 0);
        build_tpdu(8'h24, 7, 6, 0);     queue_tpdu(tpdu.size() - 2, 0);
        build_tpdu(8'h00, 6, 2, 0);     queue_tpdu(3, 0);
        build_tpdu(8'h04, 0, 0, 0);     queue_tpdu(6, 0);
        build_tpdu(8'h00, 0, 0, 0);     queue_tpdu(1, 0);
        build_tpdu(8'h02, 0, 0, 0);     queue_tpdu(0, 0);
        build_tpdu(8'h06, 0, 0, 1);     queue_tpdu(0, 0);
        build_tpdu(8'hFF, 0, 0, 4);     queue_tpdu(0, 0);
        // octet count runs past its saturation point
        build_tpdu(8'h03, 0, 0, 512);   queue_tpdu(0, 0);
        wait_drained();

        write_max_length(8'd255);
        random_tpdus(40, -1);
        wait_drained();

        send_idle_pct = 88;
        recv_idle_pct = 15;
        write_max_length(8'd2);
        random_tpdus(10, -1);
        wait_drained();
        write_max_length(8'd30);
        random_tpdus(40, -1);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_max_length(MAX_LEN_RESET);
        // receiver holds off while short reports pile up behind the output
        @(posedge i_clk);
        long_hold_left = 100;
        repeat (20) begin
            build_tpdu({6'($urandom), 2'b10}, 0, 0, 1);
            queue_tpdu(0, 0);
        end
        wait_drained();
        random_tpdus(40, 1);
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
